@@ hdl/trapezoidal_motion_profile_core_macros.svh @@
// Assertion macros used by the profile core RTL.
`ifndef TRAPEZOIDAL_MOTION_PROFILE_CORE_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TMP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define TMP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define TMP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tmp_pkg.sv @@
package tmp_pkg;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_NO_PLAN  = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [1:0] CFG_ACCEL     = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [1:0] CFG_DISTANCE  = 2'd2;

    // Handshake of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } tmp_unit_st_t;

    // Saturate a 48-bit value to 32 bits.
    function automatic logic [31:0] sat48(input logic [47:0] x);
        logic [31:0] r;
        r = (x[47:32] != 16'd0) ? 32'hFFFF_FFFF : x[31:0];
        return r;
    endfunction

    // Saturating 32-bit sum.
    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ hdl/tmp_mul.sv @@
module tmp_mul
    import tmp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [31:0]  op_a,
    input  logic [31:0]  op_b,
    output tmp_unit_st_t st,
    output logic [63:0]  product
);

    // Shift-and-add multiplier, one multiplier bit per cycle.
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = {32'd0, op_a};
            mplier_next = op_b;
            cnt_next    = 5'd31;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next    = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;
    assign product = acc_reg;

endmodule

@@ hdl/tmp_div.sv @@
module tmp_div
    import tmp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [31:0]  numer,
    input  logic [31:0]  denom,
    output tmp_unit_st_t st,
    output logic [47:0]  quotient
);

    // Restoring divider of (numer << 16) by denom, one quotient bit per cycle.
    // The dividend shifts out at the top while quotient bits shift in below.
    logic [47:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[47]};
        if (start) begin
            dvd_next  = {numer, 16'd0};
            rem_next  = '0;
            dvs_next  = denom;
            cnt_next  = 6'd47;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 32'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[46:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                dvd_next = {dvd_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign st.busy  = busy_reg;
    assign st.done  = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ hdl/tmp_sqrt.sv @@
module tmp_sqrt
    import tmp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  radicand,
    output tmp_unit_st_t st,
    output logic [31:0]  root
);

    // Digit-by-digit integer square root, two radicand bits per cycle.
    logic [63:0] x_reg, x_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] shifted;
    logic [33:0] trial;

    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], x_reg[63:62]};
        trial     = {root_reg, 2'b01};
        if (start) begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next = {x_reg[61:0], 2'b00};
            if (shifted >= trial) begin
                rem_next  = shifted - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = shifted;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;
    assign root    = root_reg;

endmodule

@@ hdl/trapezoidal_motion_profile_core.sv @@
// Trapezoidal velocity profile generator, unsigned Q16.16 throughout.
// Configuration: acceleration, top speed and distance are written through
// the plain write port (index 0, 1, 2); the user writes them only while
// the block is idle, which the block itself does not enforce. Input
// channel: one beat per request; s_tuser says restart (1) or tick (0),
// s_tdata carries the tick time. Output channel: one beat per input beat
// with the commanded position, the status code and the done and ramp-down
// flags. Multiplications, divisions and the square root run bit-serially
// on a shared shift-and-add multiplier, a restoring divider and a
// square-root unit, one bit (two for the root) per cycle, all sequenced by
// one state machine. A tick in a ramp phase takes two multiplications, a
// tick in the cruise phase one and a tick past the end none. A restart of a
// trapezoidal move takes a division, a multiplication and a second
// division; a triangular move adds a multiplication, a root and a second
// divide-multiply pass. One request is in flight at a time.
// The result sits in an output register; the next beat is accepted while it
// waits, and a further result simply waits until the receiver takes it.
// Reset (synchronous, active low) clears the configuration and the plan.
`include "trapezoidal_motion_profile_core_macros.svh"

module trapezoidal_motion_profile_core
    import tmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] tick_time
    input  logic [0:0]  s_tuser,   // [0] req_type
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] position, [33:32] status,
                                   // [34] done_res, [35] decelerating, zeros
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_DIV_RT   = 16'b0000_0000_0000_0010,
        S_MUL_RD   = 16'b0000_0000_0000_0100,
        S_CHECK    = 16'b0000_0000_0000_1000,
        S_MUL_AD   = 16'b0000_0000_0001_0000,
        S_SQRT     = 16'b0000_0000_0010_0000,
        S_DIV_CT   = 16'b0000_0000_0100_0000,
        S_SUM_CE   = 16'b0000_0000_1000_0000,
        S_COMMIT   = 16'b0000_0001_0000_0000,
        S_T_SEL    = 16'b0000_0010_0000_0000,
        S_T_MUL_Q  = 16'b0000_0100_0000_0000,
        S_T_MUL_P  = 16'b0000_1000_0000_0000,
        S_T_MUL_C  = 16'b0001_0000_0000_0000,
        S_T_FIN    = 16'b0010_0000_0000_0000,
        S_RESULT   = 16'b0100_0000_0000_0000,
        S_SPARE    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [31:0] accel_reg, max_speed_reg, distance_reg;

    // Committed plan.
    logic        planned_reg, planned_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [31:0] ramp_time_reg, ramp_time_next;
    logic [31:0] cruise_end_reg, cruise_end_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] peak_reg, peak_next;
    logic [31:0] ramp_dist_reg, ramp_dist_next;
    logic [31:0] plan_accel_reg, plan_accel_next;
    logic [31:0] plan_dist_reg, plan_dist_next;
    logic [31:0] cur_pos_reg, cur_pos_next;

    // Working values while planning or evaluating a tick.
    logic [31:0] w_sp_reg, w_sp_next;
    logic [31:0] w_rt_reg, w_rt_next;
    logic [31:0] w_rd_reg, w_rd_next;
    logic [31:0] w_ct_reg, w_ct_next;
    logic [31:0] w_ce_reg, w_ce_next;
    logic        tri_reg, tri_next;
    logic [31:0] t_reg, t_next;
    logic        down_reg, down_next;
    logic [31:0] pos_w_reg, pos_w_next;

    // Pending result and output register.
    logic [31:0] res_pos_reg, res_pos_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_done_reg, res_done_next;
    logic        res_decel_reg, res_decel_next;
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;

    // Serial units.
    logic         mul_start, div_start, sqrt_start;
    logic [31:0]  mul_a, mul_b, div_n, div_d;
    logic [63:0]  sqrt_x;
    tmp_unit_st_t mul_st, div_st, sqrt_st;
    logic [63:0]  mul_p;
    logic [47:0]  div_q;
    logic [31:0]  sqrt_r;

    logic        s_fire;
    logic        old_done, old_decel;
    logic [31:0] half_term;
    logic [31:0] q_sat;

    tmp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .st      (mul_st),
        .product (mul_p)
    );

    tmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_n),
        .denom    (div_d),
        .st       (div_st),
        .quotient (div_q)
    );

    tmp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_x),
        .st       (sqrt_st),
        .root     (sqrt_r)
    );

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg     <= '0;
            max_speed_reg <= '0;
            distance_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ACCEL:     accel_reg     <= cfg_wdata;
                CFG_MAX_SPEED: max_speed_reg <= cfg_wdata;
                CFG_DISTANCE:  distance_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Flags of the plan as it stands, used when a restart is rejected.
    assign old_done  = planned_reg && (elapsed_reg >= total_reg);
    assign old_decel = planned_reg && (cruise_end_reg < elapsed_reg)
                       && (elapsed_reg < total_reg);

    assign q_sat     = sat48(mul_p[63:16]);
    assign half_term = sat48({1'b0, mul_p[63:17]});

    always_comb begin
        state_next      = state_reg;
        planned_next    = planned_reg;
        elapsed_next    = elapsed_reg;
        ramp_time_next  = ramp_time_reg;
        cruise_end_next = cruise_end_reg;
        total_next      = total_reg;
        peak_next       = peak_reg;
        ramp_dist_next  = ramp_dist_reg;
        plan_accel_next = plan_accel_reg;
        plan_dist_next  = plan_dist_reg;
        cur_pos_next    = cur_pos_reg;
        w_sp_next       = w_sp_reg;
        w_rt_next       = w_rt_reg;
        w_rd_next       = w_rd_reg;
        w_ct_next       = w_ct_reg;
        w_ce_next       = w_ce_reg;
        tri_next        = tri_reg;
        t_next          = t_reg;
        down_next       = down_reg;
        pos_w_next      = pos_w_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        res_done_next   = res_done_reg;
        res_decel_next  = res_decel_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mul_start       = 1'b0;
        mul_a           = accel_reg;
        mul_b           = distance_reg;
        div_start       = 1'b0;
        div_n           = max_speed_reg;
        div_d           = accel_reg;
        sqrt_start      = 1'b0;
        sqrt_x          = mul_p;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0]) begin
                        if ((accel_reg == '0) || (max_speed_reg == '0)
                            || (distance_reg == '0)) begin
                            res_pos_next    = cur_pos_reg;
                            res_status_next = ST_REJECTED;
                            res_done_next   = old_done;
                            res_decel_next  = old_decel;
                            state_next      = S_RESULT;
                        end else begin
                            w_sp_next  = max_speed_reg;
                            tri_next   = 1'b0;
                            div_start  = 1'b1;
                            state_next = S_DIV_RT;
                        end
                    end else if (!planned_reg) begin
                        res_pos_next    = cur_pos_reg;
                        res_status_next = ST_NO_PLAN;
                        res_done_next   = 1'b0;
                        res_decel_next  = 1'b0;
                        state_next      = S_RESULT;
                    end else begin
                        elapsed_next = add_sat(elapsed_reg, {16'd0, s_tdata});
                        state_next   = S_T_SEL;
                    end
                end
            end
            S_DIV_RT: begin
                if (div_st.done) begin
                    w_rt_next  = sat48(div_q);
                    mul_start  = 1'b1;
                    mul_a      = w_sp_reg;
                    mul_b      = sat48(div_q);
                    state_next = S_MUL_RD;
                end
            end
            S_MUL_RD: begin
                if (mul_st.done) begin
                    w_rd_next  = half_term;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!tri_reg && ({w_rd_reg, 1'b0} > {1'b0, distance_reg})) begin
                    // Ramps overrun the distance: the move turns triangular.
                    mul_start  = 1'b1;
                    state_next = S_MUL_AD;
                end else begin
                    div_start  = 1'b1;
                    div_n      = tri_reg ? 32'd0 : 32'(distance_reg - {w_rd_reg[30:0], 1'b0});
                    div_d      = w_sp_reg;
                    state_next = S_DIV_CT;
                end
            end
            S_MUL_AD: begin
                if (mul_st.done) begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_st.done) begin
                    if (sqrt_r == '0) begin
                        res_pos_next    = cur_pos_reg;
                        res_status_next = ST_REJECTED;
                        res_done_next   = old_done;
                        res_decel_next  = old_decel;
                        state_next      = S_RESULT;
                    end else begin
                        w_sp_next  = sqrt_r;
                        tri_next   = 1'b1;
                        div_start  = 1'b1;
                        div_n      = sqrt_r;
                        state_next = S_DIV_RT;
                    end
                end
            end
            S_DIV_CT: begin
                if (div_st.done) begin
                    w_ct_next  = sat48(div_q);
                    state_next = S_SUM_CE;
                end
            end
            S_SUM_CE: begin
                w_ce_next  = add_sat(w_rt_reg, w_ct_reg);
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                total_next      = add_sat(w_ce_reg, w_rt_reg);
                cruise_end_next = w_ce_reg;
                ramp_time_next  = w_rt_reg;
                ramp_dist_next  = w_rd_reg;
                peak_next       = w_sp_reg;
                plan_accel_next = accel_reg;
                plan_dist_next  = distance_reg;
                elapsed_next    = '0;
                planned_next    = 1'b1;
                res_pos_next    = cur_pos_reg;
                // Elapsed time is zero, so the move is done only if it is empty.
                res_done_next   = (add_sat(w_ce_reg, w_rt_reg) == '0);
                res_decel_next  = 1'b0;
                res_status_next = (add_sat(w_ce_reg, w_rt_reg) == '0) ?
                                  ST_FINISHED : ST_RUNNING;
                state_next      = S_RESULT;
            end
            S_T_SEL: begin
                if (total_reg < elapsed_reg) begin
                    pos_w_next = plan_dist_reg;
                    state_next = S_T_FIN;
                end else if (elapsed_reg < ramp_time_reg) begin
                    t_next     = elapsed_reg;
                    down_next  = 1'b0;
                    mul_start  = 1'b1;
                    mul_a      = plan_accel_reg;
                    mul_b      = elapsed_reg;
                    state_next = S_T_MUL_Q;
                end else if (elapsed_reg < cruise_end_reg) begin
                    mul_start  = 1'b1;
                    mul_a      = peak_reg;
                    mul_b      = elapsed_reg - ramp_time_reg;
                    state_next = S_T_MUL_C;
                end else begin
                    t_next     = total_reg - elapsed_reg;
                    down_next  = 1'b1;
                    mul_start  = 1'b1;
                    mul_a      = plan_accel_reg;
                    mul_b      = total_reg - elapsed_reg;
                    state_next = S_T_MUL_Q;
                end
            end
            S_T_MUL_Q: begin
                if (mul_st.done) begin
                    mul_start  = 1'b1;
                    mul_a      = q_sat;
                    mul_b      = t_reg;
                    state_next = S_T_MUL_P;
                end
            end
            S_T_MUL_P: begin
                if (mul_st.done) begin
                    if (down_reg) begin
                        pos_w_next = (plan_dist_reg > half_term) ?
                                     plan_dist_reg - half_term : 32'd0;
                    end else begin
                        pos_w_next = half_term;
                    end
                    state_next = S_T_FIN;
                end
            end
            S_T_MUL_C: begin
                if (mul_st.done) begin
                    pos_w_next = add_sat(ramp_dist_reg, q_sat);
                    state_next = S_T_FIN;
                end
            end
            S_T_FIN: begin
                cur_pos_next    = pos_w_reg;
                res_pos_next    = pos_w_reg;
                res_done_next   = (elapsed_reg >= total_reg);
                res_decel_next  = (cruise_end_reg < elapsed_reg)
                                  && (elapsed_reg < total_reg);
                res_status_next = (elapsed_reg >= total_reg) ? ST_FINISHED : ST_RUNNING;
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                // Hand over once the output register is free or being emptied.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, res_decel_reg, res_done_reg,
                                    res_status_reg, res_pos_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            planned_reg    <= 1'b0;
            elapsed_reg    <= '0;
            ramp_time_reg  <= '0;
            cruise_end_reg <= '0;
            total_reg      <= '0;
            peak_reg       <= '0;
            ramp_dist_reg  <= '0;
            plan_accel_reg <= '0;
            plan_dist_reg  <= '0;
            cur_pos_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            planned_reg    <= planned_next;
            elapsed_reg    <= elapsed_next;
            ramp_time_reg  <= ramp_time_next;
            cruise_end_reg <= cruise_end_next;
            total_reg      <= total_next;
            peak_reg       <= peak_next;
            ramp_dist_reg  <= ramp_dist_next;
            plan_accel_reg <= plan_accel_next;
            plan_dist_reg  <= plan_dist_next;
            cur_pos_reg    <= cur_pos_next;
            m_valid_reg    <= m_valid_next;
        end
        w_sp_reg       <= w_sp_next;
        w_rt_reg       <= w_rt_next;
        w_rd_reg       <= w_rd_next;
        w_ct_reg       <= w_ct_next;
        w_ce_reg       <= w_ce_next;
        tri_reg        <= tri_next;
        t_reg          <= t_next;
        down_reg       <= down_next;
        pos_w_reg      <= pos_w_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        res_done_reg   <= res_done_next;
        res_decel_reg  <= res_decel_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `TMP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_fire, state_reg != S_IDLE, "accepted beat left the sequencer idle")
    `TMP_ASSERT_IMP(a_units_quiet_idle, aclk, aresetn, state_reg == S_IDLE, !mul_st.busy && !div_st.busy && !sqrt_st.busy, "serial unit busy while idle")
    `TMP_ASSERT_IMP(a_no_plan_no_time, aclk, aresetn, !planned_reg, elapsed_reg == '0, "elapsed time moved without a plan")
    `TMP_ASSERT_IMP(a_flags_exclusive, aclk, aresetn, m_valid_reg, !(m_data_reg[34] && m_data_reg[35]), "done and ramp-down flags both set")

endmodule

@@ tb/tb_trapezoidal_motion_profile_core.sv @@
`default_nettype none

// Self-checking bench for the trapezoidal profile core. A directed table of
// restarts and ticks opens the run (no-plan ticks, rejected restarts, extreme
// settings, triangular and trapezoidal moves). Then random phases follow,
// each with fresh settings and a batch of ticks played through the move.
// Every result beat is checked against a profile model kept in the bench.
module tb_trapezoidal_motion_profile_core;
    import tmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ERR_PRINT = 10;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 400;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic [31:0] position;
        logic [1:0]  status;
        logic        done_res;
        logic        decel;
    } profile_out_t;

    // One row of the directed table. Where check_exp is set, the expected
    // beat is typed in and compared with the model's own answer as well.
    typedef struct {
        logic        set_cfg;
        logic [31:0] acc;
        logic [31:0] spd;
        logic [31:0] mv_dist;
        logic        req;
        logic [15:0] tick;
        logic        check_exp;
        profile_out_t exp_out;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] tick_time
    logic [0:0]  s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] position, [33:32] status, [34] done, [35] decel

    trapezoidal_motion_profile_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Model copy of the registers and of the plan.
    logic [31:0] reg_accel, reg_speed, reg_dist;
    logic        mp_planned;
    logic [31:0] mp_elapsed, mp_ramp_t, mp_cruise_end, mp_total;
    logic [31:0] mp_peak, mp_ramp_d, mp_accel, mp_dist, mp_pos;

    profile_out_t pending_profile[$];
    int  mismatches;
    int  beats_in, beats_out;
    int  stall_cycles;
    int  rx_gap;           // remaining cycles of a long receiver pause
    bit  hold_off_req;     // asks the receiver for one long hold-off
    bit  rx_busy_hold;

    function automatic logic [31:0] clip32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] half_at2(input logic [31:0] a, input logic [31:0] t);
        logic [31:0] q;
        q = clip32((64'(a) * 64'(t)) >> 16);
        return clip32((64'(q) * 64'(t)) >> 17);
    endfunction

    function automatic logic [31:0] pos_at(input logic [31:0] e);
        logic [31:0] sub;
        if (mp_total < e) return mp_dist;
        if (e < mp_ramp_t) return half_at2(mp_accel, e);
        if (e < mp_cruise_end)
            return clip32(64'(mp_ramp_d)
                          + ((64'(mp_peak) * 64'(e - mp_ramp_t)) >> 16));
        sub = half_at2(mp_accel, mp_total - e);
        return (mp_dist > sub) ? mp_dist - sub : 32'd0;
    endfunction

    // Plans a move from the registers; returns 0 when a setting rules it out.
    function automatic bit plan_move();
        logic [31:0] sp, rt, rd, cd, ct, ce;
        if (reg_accel == 0 || reg_speed == 0 || reg_dist == 0) return 1'b0;
        sp = reg_speed;
        rt = clip32((64'(sp) << 16) / reg_accel);
        rd = clip32((64'(sp) * 64'(rt)) >> 17);
        if (2 * 64'(rd) > 64'(reg_dist)) begin
            sp = root64(64'(reg_accel) * 64'(reg_dist));
            if (sp == 0) return 1'b0;
            rt = clip32((64'(sp) << 16) / reg_accel);
            rd = clip32((64'(sp) * 64'(rt)) >> 17);
            cd = 0;
        end else begin
            cd = reg_dist - 2 * rd;
        end
        ct = clip32((64'(cd) << 16) / sp);
        ce = clip32(64'(rt) + 64'(ct));
        mp_accel = reg_accel;
        mp_dist = reg_dist;
        mp_peak = sp;
        mp_ramp_t = rt;
        mp_ramp_d = rd;
        mp_cruise_end = ce;
        mp_total = clip32(64'(ce) + 64'(rt));
        mp_elapsed = 0;
        mp_planned = 1'b1;
        return 1'b1;
    endfunction

    function automatic profile_out_t step_profile(input logic req, input logic [15:0] tick);
        profile_out_t o;
        bit ok;
        o = '0;
        if (req == REQ_RESTART) begin
            ok = plan_move();
            if (mp_planned) begin
                o.done_res = mp_elapsed >= mp_total;
                o.decel = mp_cruise_end < mp_elapsed && mp_elapsed < mp_total;
            end
            o.status = !ok ? ST_REJECTED : (o.done_res ? ST_FINISHED : ST_RUNNING);
        end else if (!mp_planned) begin
            o.status = ST_NO_PLAN;
        end else begin
            mp_elapsed = clip32(64'(mp_elapsed) + 64'(tick));
            mp_pos = pos_at(mp_elapsed);
            o.done_res = mp_elapsed >= mp_total;
            o.decel = mp_cruise_end < mp_elapsed && mp_elapsed < mp_total;
            o.status = o.done_res ? ST_FINISHED : ST_RUNNING;
        end
        o.position = mp_pos;
        return o;
    endfunction

    task automatic note_mismatch(input string what, input profile_out_t e, input profile_out_t a);
        mismatches++;
        if (mismatches <= MAX_ERR_PRINT)
            $display("%s: expected pos=%h st=%0d done=%0b dec=%0b, got pos=%h st=%0d done=%0b dec=%0b",
                     what, e.position, e.status, e.done_res, e.decel,
                     a.position, a.status, a.done_res, a.decel);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ACCEL:     reg_accel = val;
            CFG_MAX_SPEED: reg_speed = val;
            default:       reg_dist  = val;
        endcase
    endtask

    task automatic set_move(input logic [31:0] a, input logic [31:0] v, input logic [31:0] d);
        write_reg(CFG_ACCEL, a);
        write_reg(CFG_MAX_SPEED, v);
        write_reg(CFG_DISTANCE, d);
    endtask

    // Registers may only change once the block has drained.
    task automatic wait_idle();
        while (pending_profile.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sends one beat, after a random gap if gaps is set; valid stays high across
    // back-to-back beats, so it is never dropped and raised within one edge.
    task automatic send_item(input logic req, input logic [15:0] tick, input bit gaps);
        int gap;
        gap = 0;
        if (gaps) gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 2);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= tick;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_profile.push_back(step_profile(req, tick));
        beats_in++;
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random back-pressure with the odd long pause, plus one long
    // hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (hold_off_req || rx_busy_hold) begin
            m_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else if ($urandom_range(0, 49) == 0) begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(10, 60);
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        rx_busy_hold = 1'b0;
        wait (hold_off_req);
        rx_busy_hold = 1'b1;
        hold_off_req = 1'b0;
        repeat (3000) @(posedge aclk);
        rx_busy_hold = 1'b0;
    end

    // Output checking.
    always @(posedge aclk) begin
        profile_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.position = m_tdata[31:0];
            got.status   = m_tdata[33:32];
            got.done_res = m_tdata[34];
            got.decel    = m_tdata[35];
            beats_out++;
            if (pending_profile.size() == 0) begin
                note_mismatch("unexpected result beat", '0, got);
            end else begin
                want = pending_profile.pop_front();
                if (got !== want || m_tdata[39:36] !== 4'd0)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    stim_row_t dir_rows[$];

    function automatic stim_row_t mk(input logic sc, input logic [31:0] a,
                                     input logic [31:0] v, input logic [31:0] d,
                                     input logic rq, input logic [15:0] t,
                                     input logic ce, input profile_out_t eo);
        stim_row_t r;
        r.set_cfg = sc; r.acc = a; r.spd = v; r.mv_dist = d;
        r.req = rq; r.tick = t; r.check_exp = ce; r.exp_out = eo;
        return r;
    endfunction

    initial begin
        int n, ticks;
        profile_out_t m;
        stim_row_t row;
        logic [31:0] a, v, d;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        hold_off_req = 1'b0;
        mismatches = 0; beats_in = 0; beats_out = 0; stall_cycles = 0;
        reg_accel = 0; reg_speed = 0; reg_dist = 0;
        mp_planned = 0; mp_elapsed = 0; mp_ramp_t = 0; mp_cruise_end = 0;
        mp_total = 0; mp_peak = 0; mp_ramp_d = 0; mp_accel = 0; mp_dist = 0; mp_pos = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: no-plan ticks, rejected restarts, then real moves.
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'hFFFF, 1, '{0, ST_NO_PLAN, 0, 0}));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'h0000, 1, '{0, ST_NO_PLAN, 0, 0}));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_RESTART, 16'hFFFF, 1, '{0, ST_REJECTED, 0, 0}));
        dir_rows.push_back(mk(1, 32'h1_0000, 32'h1_0000, 0, REQ_RESTART, 0, 1,
                              '{0, ST_REJECTED, 0, 0}));
        dir_rows.push_back(mk(1, 32'h1_0000, 32'h1_0000, 32'h10_0000, REQ_RESTART, 0, 1,
                              '{0, ST_RUNNING, 0, 0}));
        for (int i = 0; i < 6; i++)
            dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'hFFFF, 0, '0));
        dir_rows.push_back(mk(1, 0, 32'h1_0000, 32'h10_0000, REQ_RESTART, 0, 0, '0));
        dir_rows.push_back(mk(1, 32'h2_0000, 32'h40_0000, 32'h1_0000, REQ_RESTART, 0, 0, '0));
        for (int i = 0; i < 4; i++)
            dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'h4000, 0, '0));
        dir_rows.push_back(mk(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              REQ_RESTART, 0, 0, '0));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'h8001, 0, '0));
        dir_rows.push_back(mk(1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, REQ_RESTART, 0, 0, '0));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'hFFFF, 0, '0));
        dir_rows.push_back(mk(1, 32'd1, 32'd1, 32'd1, REQ_RESTART, 0, 0, '0));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'h0001, 0, '0));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'hAAAA, 0, '0));
        dir_rows.push_back(mk(0, 0, 0, 0, REQ_TICK, 16'h5555, 0, '0));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.set_cfg) begin
                end_burst();
                wait_idle();
                set_move(row.acc, row.spd, row.mv_dist);
            end
            if (row.check_exp) begin
                // The model must agree with the typed-in row before it is trusted.
                m = step_profile(row.req, row.tick);
                if (m !== row.exp_out) note_mismatch("directed row", row.exp_out, m);
                pending_profile.push_back(m);
                s_tvalid <= 1'b1;
                s_tuser  <= row.req;
                s_tdata  <= row.tick;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                beats_in++;
            end else begin
                send_item(row.req, row.tick, 1'b0);
            end
        end
        end_burst();

        // Random phases: fresh settings, a restart, then ticks through the move.
        n = 0;
        while (beats_in < 720) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: begin a = $urandom; v = $urandom; d = $urandom; end
                1: begin a = 32'hFFFF_FFFF; v = $urandom_range(1, 32'h100_0000);
                         d = $urandom; end
                2: begin a = $urandom_range(0, 3); v = $urandom_range(0, 3);
                         d = $urandom_range(0, 3); end
                default: begin
                    a = $urandom_range(32'h1000, 32'h40_0000);
                    v = $urandom_range(32'h1000, 32'h40_0000);
                    d = $urandom_range(32'h1000, 32'h400_0000);
                end
            endcase
            set_move(a, v, d);
            if (n == 3) hold_off_req = 1'b1;
            ticks = $urandom_range(10, 40);
            send_item(REQ_RESTART, 16'($urandom), 1'b1);
            for (int k = 0; k < ticks; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(REQ_RESTART, 16'($urandom), 1'b1);
                else
                    send_item(REQ_TICK, 16'($urandom), 1'b1);
            end
            if (n == 5) begin
                // Sender pauses until every result has come back.
                end_burst();
                while (pending_profile.size() != 0) @(posedge aclk);
            end
            end_burst();
            n++;
        end

        while (pending_profile.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d input beats and %0d result beats over %0d random move phases,",
                 beats_in, beats_out, n);
        $display("with ramps, cruise, triangular moves, rejected restarts and saturation.");
        if (mismatches == 0 && pending_profile.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ trapezoidal_motion_profile_core.f @@
+incdir+hdl
hdl/tmp_pkg.sv
hdl/tmp_mul.sv
hdl/tmp_div.sv
hdl/tmp_sqrt.sv
hdl/trapezoidal_motion_profile_core.sv
tb/tb_trapezoidal_motion_profile_core.sv
